### rtl/rational_arithmetic_unit_defines.svh
// assertion helpers shared by the rtl files
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RAU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rau_pkg.sv
package rau_pkg;
	localparam int FUNC_W = 3;
	localparam int RES_W = 63;
	localparam int OPERAND_WIDTH_DEF = 31;

	localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CMP = 3'd4;
endpackage

### rtl/rau_div.sv
`include "rational_arithmetic_unit_defines.svh"

module rau_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [rau_pkg::RES_W-1:0] dividend,
	input  logic [rau_pkg::RES_W-1:0] divisor,
	output logic                    done,
	output logic [rau_pkg::RES_W-1:0] quotient,
	output logic [rau_pkg::RES_W-1:0] remainder
);
	import rau_pkg::*;

	localparam int CNT_W = $clog2(RES_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RES_W-1:0]   rem_q;
	logic [RES_W-1:0]   quo_q;
	logic [RES_W-1:0]   dsr_q;
	logic [RES_W:0]     shifted;
	logic [RES_W:0]     diff;
	logic               fits;

	// one restoring step per cycle
	assign shifted = {rem_q, quo_q[RES_W-1]};
	assign diff = shifted - {1'b0, dsr_q};
	assign fits = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(RES_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[RES_W-1:0] : shifted[RES_W-1:0];
			quo_q <= {quo_q[RES_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	`RAU_ASSERT_IMPL(a_div_nonzero, start, divisor != '0, "divide started with zero divisor")
	`RAU_ASSERT_IMPL(a_div_idle_start, start, !busy_q, "divide started while busy")
	`RAU_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q, "done held for more than a cycle")
endmodule

### rtl/rational_arithmetic_unit.sv
// channel | direction | handshake           | payload
// in      | receive   | in_valid / in_stall | func, left_*, right_*
// out     | send      | out_valid/out_stall | result_*, less_than, equal, div_by_zero
//
// error and unused codes go straight to the output state; compare runs the multiply
// states and the combine step; the other codes then run the euclid steps and the reductions
// of numerator and denominator on the shared bit-serial divider (one quotient bit a cycle)
// reset clears the sequencer and the divider control, payload is not reset
// in_stall is high from acceptance until the result item has been taken
// out_valid holds with a stable payload while out_stall is high
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rau_pkg::FUNC_W-1:0]   func,
	input  logic                         left_negative,
	input  logic [OPERAND_WIDTH-1:0]     left_numerator,
	input  logic [OPERAND_WIDTH-1:0]     left_denominator,
	input  logic                         right_negative,
	input  logic [OPERAND_WIDTH-1:0]     right_numerator,
	input  logic [OPERAND_WIDTH-1:0]     right_denominator,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         result_negative,
	output logic [rau_pkg::RES_W-1:0]    result_numerator,
	output logic [rau_pkg::RES_W-1:0]    result_denominator,
	output logic                         less_than,
	output logic                         equal,
	output logic                         div_by_zero
);
	import rau_pkg::*;

	localparam int W = OPERAND_WIDTH;

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MUL_A    = 4'd1;
	localparam logic [3:0] S_MUL_B    = 4'd2;
	localparam logic [3:0] S_MUL_D    = 4'd3;
	localparam logic [3:0] S_COMB     = 4'd4;
	localparam logic [3:0] S_GCD      = 4'd5;
	localparam logic [3:0] S_GCD_WAIT = 4'd6;
	localparam logic [3:0] S_QN_WAIT  = 4'd7;
	localparam logic [3:0] S_QD_WAIT  = 4'd8;
	localparam logic [3:0] S_OUT      = 4'd9;

	logic [3:0]        state_q;

	// captured operands
	logic [FUNC_W-1:0] fn_q;
	logic              lsign_q, rsign_q;
	logic              lneg_q, rneg_q;
	logic [W-1:0]      ln_q, ld_q, rn_q, rd_q;

	// products and euclid registers
	logic [RES_W-1:0]  a_q, b_q, d_q;
	logic              ge_q, eqab_q;
	logic [RES_W-1:0]  x_q, y_q;
	logic              sneg_q;

	// result item
	logic              res_neg_q, lt_q, eq_q, err_q;
	logic [RES_W-1:0]  num_q, den_q;

	// shared multiplier
	logic [W-1:0]      mul_x, mul_y;
	logic [2*W-1:0]    prod;
	logic [RES_W-1:0]  prod_ext;

	// shared divider
	logic              div_start, div_done;
	logic [RES_W-1:0]  div_dividend, div_divisor, div_quo, div_rem;

	// combine stage
	logic              bneg;
	logic [RES_W-1:0]  sum_val;

	logic              accept;
	logic              in_err;

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign in_err = (left_denominator == '0) || (right_denominator == '0)
		|| (func == FN_DIV && right_numerator == '0);

	// operand select: a = ln*rd (ln*rn for multiply), b = rn*ld, d = ld*rd
	always_comb begin
		mul_x = ld_q;
		mul_y = rd_q;
		case (state_q)
			S_MUL_A: begin
				mul_x = ln_q;
				mul_y = (fn_q == FN_MUL) ? rn_q : rd_q;
			end
			S_MUL_B: begin
				mul_x = rn_q;
				mul_y = ld_q;
			end
			default: begin
				mul_x = ld_q;
				mul_y = rd_q;
			end
		endcase
	end

	assign prod = mul_x * mul_y;
	assign prod_ext = RES_W'(prod);

	// signed add of two magnitudes, the compare was registered in S_MUL_D
	assign bneg = (fn_q == FN_SUB) ? !rsign_q : rsign_q;
	always_comb begin
		if (lsign_q == bneg) begin
			sum_val = a_q + b_q;
		end else if (ge_q) begin
			sum_val = a_q - b_q;
		end else begin
			sum_val = b_q - a_q;
		end
	end

	// divider requests: euclid remainder steps, then the two reductions
	always_comb begin
		div_start = 1'b0;
		div_dividend = x_q;
		div_divisor = y_q;
		case (state_q)
			S_GCD: begin
				div_start = 1'b1;
				if (y_q == '0) begin
					div_dividend = num_q;
					div_divisor = x_q;
				end
			end
			S_QN_WAIT: begin
				div_start = div_done;
				div_dividend = den_q;
				div_divisor = x_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	rau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func > FN_CMP || in_err) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL_A;
						end
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_MUL_D;
				S_MUL_D: state_q <= S_COMB;
				S_COMB: state_q <= (fn_q == FN_CMP) ? S_OUT : S_GCD;
				S_GCD: state_q <= (y_q == '0) ? S_QN_WAIT : S_GCD_WAIT;
				S_GCD_WAIT: begin
					if (div_done) begin
						state_q <= S_GCD;
					end
				end
				S_QN_WAIT: begin
					if (div_done) begin
						state_q <= S_QD_WAIT;
					end
				end
				S_QD_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					fn_q <= func;
					lsign_q <= left_negative;
					rsign_q <= right_negative;
					lneg_q <= left_negative && (left_numerator != '0);
					rneg_q <= right_negative && (right_numerator != '0);
					ln_q <= left_numerator;
					ld_q <= left_denominator;
					rn_q <= right_numerator;
					rd_q <= right_denominator;
					res_neg_q <= 1'b0;
					num_q <= '0;
					den_q <= '0;
					lt_q <= 1'b0;
					eq_q <= 1'b0;
					err_q <= (func <= FN_CMP) && in_err;
				end
			end
			S_MUL_A: a_q <= prod_ext;
			S_MUL_B: b_q <= prod_ext;
			S_MUL_D: begin
				d_q <= prod_ext;
				ge_q <= a_q >= b_q;
				eqab_q <= a_q == b_q;
			end
			S_COMB: begin
				case (fn_q)
					FN_CMP: begin
						if (!lneg_q && !rneg_q) begin
							lt_q <= !ge_q;
						end else if (lneg_q && rneg_q) begin
							lt_q <= ge_q && !eqab_q;
						end else begin
							lt_q <= lneg_q;
						end
						eq_q <= (lneg_q == rneg_q) && eqab_q;
					end
					FN_MUL: begin
						num_q <= a_q;
						den_q <= d_q;
						x_q <= a_q;
						y_q <= d_q;
						sneg_q <= lsign_q != rsign_q;
					end
					FN_DIV: begin
						num_q <= a_q;
						den_q <= b_q;
						x_q <= a_q;
						y_q <= b_q;
						sneg_q <= lsign_q != rsign_q;
					end
					default: begin
						num_q <= sum_val;
						den_q <= d_q;
						x_q <= sum_val;
						y_q <= d_q;
						sneg_q <= (lsign_q == bneg || ge_q) ? lsign_q : bneg;
					end
				endcase
			end
			S_GCD_WAIT: begin
				if (div_done) begin
					x_q <= y_q;
					y_q <= div_rem;
				end
			end
			S_QN_WAIT: begin
				if (div_done) begin
					num_q <= div_quo;
				end
			end
			S_QD_WAIT: begin
				if (div_done) begin
					den_q <= div_quo;
					// zero result carries no sign
					res_neg_q <= sneg_q && (num_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = state_q == S_OUT;
	assign result_negative = res_neg_q;
	assign result_numerator = num_q;
	assign result_denominator = den_q;
	assign less_than = lt_q;
	assign equal = eq_q;
	assign div_by_zero = err_q;

	`RAU_ASSERT_IMPL(a_err_zero, out_valid && div_by_zero, (result_numerator == '0) && (result_denominator == '0) && !result_negative, "error item carries a value")
	`RAU_ASSERT_IMPL(a_lt_eq_excl, out_valid, !(less_than && equal), "less and equal both set")
	`RAU_ASSERT_IMPL(a_div_in_gcd, div_start, (state_q == S_GCD) || (state_q == S_QN_WAIT), "divider started outside reduction")
	`RAU_ASSERT_IMPL(a_idle_no_out, !in_stall, !out_valid, "input open while result pending")
endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
	import rau_pkg::*;

	localparam int OW = OPERAND_WIDTH_DEF;
	// codes that the block does no work for
	localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
	// the limit must cover the worst item, then the receiver stall on top
	localparam int IDLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 490;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic              lneg;
		logic [OW-1:0]     lnum;
		logic [OW-1:0]     lden;
		logic              rneg;
		logic [OW-1:0]     rnum;
		logic [OW-1:0]     rden;
	} frac_pair_t;

	typedef struct {
		logic             neg;
		logic [RES_W-1:0] num;
		logic [RES_W-1:0] den;
		logic             lt;
		logic             eq;
		logic             err;
	} frac_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic left_negative = 1'b0;
	logic [OW-1:0] left_numerator = '0;
	logic [OW-1:0] left_denominator = '0;
	logic right_negative = 1'b0;
	logic [OW-1:0] right_numerator = '0;
	logic [OW-1:0] right_denominator = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_negative;
	logic [RES_W-1:0] result_numerator;
	logic [RES_W-1:0] result_denominator;
	logic less_than;
	logic equal;
	logic div_by_zero;

	// pending reduced fractions, oldest first
	frac_result_t reduced_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	rational_arithmetic_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .left_negative(left_negative),
		.left_numerator(left_numerator), .left_denominator(left_denominator),
		.right_negative(right_negative),
		.right_numerator(right_numerator), .right_denominator(right_denominator),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_negative(result_negative),
		.result_numerator(result_numerator), .result_denominator(result_denominator),
		.less_than(less_than), .equal(equal), .div_by_zero(div_by_zero)
	);

	// cross multiply, then reduce by euclid at full 64-bit width
	function automatic frac_result_t reduce_fraction(frac_pair_t p);
		logic [63:0] ln, ld, rn, rd, a, b, num, den, x, y, t;
		logic sneg, bneg, lneg, rneg;
		frac_result_t r;
		r = '{default: '0};
		ln = 64'(p.lnum);
		ld = 64'(p.lden);
		rn = 64'(p.rnum);
		rd = 64'(p.rden);
		sneg = 1'b0;
		num = '0;
		den = '0;
		if (p.func <= FN_CMP) begin
			if (ld == 0 || rd == 0 || (p.func == FN_DIV && rn == 0)) begin
				r.err = 1'b1;
			end else if (p.func == FN_CMP) begin
				// zero is positive whatever its sign bit
				lneg = p.lneg && ln != 0;
				rneg = p.rneg && rn != 0;
				a = ln * rd;
				b = rn * ld;
				if (!lneg && !rneg) r.lt = a < b;
				else if (lneg && rneg) r.lt = a > b;
				else r.lt = lneg;
				r.eq = (lneg == rneg) && (a == b);
			end else begin
				if (p.func == FN_ADD || p.func == FN_SUB) begin
					a = ln * rd;
					b = rn * ld;
					bneg = (p.func == FN_SUB) ? !p.rneg : p.rneg;
					den = ld * rd;
					if (p.lneg == bneg) begin
						num = a + b;
						sneg = p.lneg;
					end else if (a >= b) begin
						num = a - b;
						sneg = p.lneg;
					end else begin
						num = b - a;
						sneg = bneg;
					end
				end else if (p.func == FN_MUL) begin
					num = ln * rn;
					den = ld * rd;
					sneg = p.lneg != p.rneg;
				end else begin
					num = ln * rd;
					den = ld * rn;
					sneg = p.lneg != p.rneg;
				end
				x = num;
				y = den;
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
				if (x != 0) begin
					num = num / x;
					den = den / x;
				end
				r.num = num[RES_W-1:0];
				r.den = den[RES_W-1:0];
				r.neg = sneg && num != 0;
			end
		end
		return r;
	endfunction

	// present one item, hold it until taken, then maybe leave a gap
	task automatic send_item(frac_pair_t p);
		func <= p.func;
		left_negative <= p.lneg;
		left_numerator <= p.lnum;
		left_denominator <= p.lden;
		right_negative <= p.rneg;
		right_numerator <= p.rnum;
		right_denominator <= p.rden;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		reduced_q.push_back(reduce_fraction(p));
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		frac_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (reduced_q.size() == 0) begin
				$display("%0t unexpected result item, expected none actual num %0h",
					$time, result_numerator);
				errors++;
			end else begin
				e = reduced_q.pop_front();
				report_field("result_negative", 64'(e.neg), 64'(result_negative));
				report_field("result_numerator", 64'(e.num), 64'(result_numerator));
				report_field("result_denominator", 64'(e.den), 64'(result_denominator));
				report_field("less_than", 64'(e.lt), 64'(less_than));
				report_field("equal", 64'(e.eq), 64'(equal));
				report_field("div_by_zero", 64'(e.err), 64'(div_by_zero));
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [OW-1:0] pick_magnitude();
		int k;
		k = $urandom_range(9);
		if (k == 0) return OW'($urandom);
		if (k == 1) return $urandom_range(1) ? {OW{1'b1}} : '0;
		return OW'($urandom_range(1, 1 << $urandom_range(1, 16)));
	endfunction

	function automatic frac_pair_t pick_pair();
		frac_pair_t p;
		logic [OW-1:0] m;
		p.func = ($urandom_range(99) < 3) ? FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI))
			: FUNC_W'($urandom_range(FN_ADD, FN_CMP));
		p.lneg = 1'($urandom_range(1));
		p.rneg = 1'($urandom_range(1));
		p.lnum = pick_magnitude();
		p.rnum = pick_magnitude();
		p.lden = ($urandom_range(99) < 4) ? '0 : pick_magnitude();
		p.rden = ($urandom_range(99) < 4) ? '0 : pick_magnitude();
		if (p.lden == 0 && $urandom_range(1)) p.lden = OW'(1);
		// equal values in different terms, to hit the equal flag
		if (p.func == FN_CMP && $urandom_range(99) < 30) begin
			m = OW'($urandom_range(1, 200));
			p.lnum = OW'($urandom_range(0, 60000));
			p.lden = OW'($urandom_range(1, 60000));
			p.rnum = p.lnum * m;
			p.rden = p.lden * m;
			if ($urandom_range(1)) p.rneg = p.lneg;
		end
		return p;
	endfunction

	task automatic test_directed();
		localparam logic [OW-1:0] MX = {OW{1'b1}};
		frac_pair_t p;
		// every code with plain operands
		for (int f = FN_ADD; f <= FN_UNUSED_HI; f++) begin
			p = '{FUNC_W'(f), 1'b0, OW'(3), OW'(4), 1'b1, OW'(5), OW'(6)};
			send_item(p);
		end
		// widest operands
		send_item('{FN_ADD, 1'b0, MX, MX, 1'b0, MX, MX});
		send_item('{FN_SUB, 1'b1, MX, OW'(1), 1'b0, MX, OW'(1)});
		send_item('{FN_MUL, 1'b1, MX, OW'(1), 1'b1, MX, MX});
		send_item('{FN_DIV, 1'b0, MX, OW'(1), 1'b1, OW'(1), MX});
		// zero result is positive
		send_item('{FN_SUB, 1'b1, OW'(7), OW'(9), 1'b1, OW'(7), OW'(9)});
		send_item('{FN_MUL, 1'b1, OW'(0), OW'(5), 1'b0, OW'(3), OW'(2)});
		// zero operand denominator
		send_item('{FN_ADD, 1'b0, OW'(1), OW'(0), 1'b0, OW'(1), OW'(1)});
		send_item('{FN_CMP, 1'b0, OW'(1), OW'(1), 1'b1, OW'(1), OW'(0)});
		// division by a zero numerator
		send_item('{FN_DIV, 1'b1, OW'(5), OW'(3), 1'b0, OW'(0), OW'(8)});
		// zeros of either sign compare equal
		send_item('{FN_CMP, 1'b1, OW'(0), OW'(3), 1'b0, OW'(0), OW'(7)});
		// two negatives compare strictly, then mixed and positive signs
		send_item('{FN_CMP, 1'b1, OW'(1), OW'(2), 1'b1, OW'(2), OW'(4)});
		send_item('{FN_CMP, 1'b1, OW'(1), OW'(3), 1'b1, OW'(1), OW'(2)});
		send_item('{FN_CMP, 1'b0, MX, OW'(1), 1'b1, MX, OW'(1)});
		send_item('{FN_CMP, 1'b0, OW'(2), OW'(5), 1'b0, OW'(1), OW'(2)});
	endtask

	task automatic test_random(int n);
		repeat (n) send_item(pick_pair());
	endtask

	// sender holds off until the block has handed back everything
	task automatic test_drain_pause();
		in_valid <= 1'b0;
		while (reduced_q.size() != 0) @(posedge clk);
		test_random(10);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 28;
		recv_idle_pct = 87;
		test_random(ITEMS_PER_PHASE);
		test_drain_pause();
		send_idle_pct = 87;
		recv_idle_pct = 28;
		test_random(ITEMS_PER_PHASE);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(ITEMS_PER_PHASE);
		in_valid <= 1'b0;
		while (reduced_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
